### sv/lrg_pkg.sv
// Shared types and constants for the Lehmer random generator.
// No dependencies; every other file imports this package.
package lrg_pkg;

  localparam logic [15:0] LehmerMult  = 16'hbc8f;
  localparam logic [30:0] LehmerMod   = 31'h7fffffff;
  localparam logic [31:0] DefaultSeed = 32'h075bd924;

  typedef enum logic [0:0] {
    CMD_DRAW    = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_SEED = 1'b0
  } reg_idx_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] range_low;
    logic [31:0] range_high;
  } in_item_t;

  typedef struct packed {
    logic [30:0] raw_value;
    logic [31:0] ranged_value;
  } out_item_t;

  // One draw handed from the front end to the reduction back end.
  typedef struct packed {
    logic [30:0] raw;
    logic [31:0] low;
    logic [31:0] span;
  } job_t;

endpackage

### sv/lrg_front.sv
// Front end: takes requests, steps the generator state, queues draws.
// Depends on lrg_pkg.
module lrg_front import lrg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  in_item_t    item_i,
  input  logic [31:0] seed_i,
  output logic        job_push_o,
  output job_t        job_o
);

  logic [31:0] cur_q, cur_d;
  logic [47:0] prod;
  logic [31:0] sum1;
  logic [30:0] sum2;
  logic [30:0] nxt;

  // Fold the product twice modulo 2^31-1.
  always_comb begin
    prod = 48'(cur_q) * 48'(LehmerMult);
    sum1 = {15'b0, prod[47:31]} + {1'b0, prod[30:0]};
    sum2 = sum1[30:0] + {30'b0, sum1[31]};
    if (sum2 == LehmerMod || sum2 == '0) begin
      nxt = DefaultSeed[30:0];
    end else begin
      nxt = sum2;
    end
  end

  always_comb begin
    cur_d      = cur_q;
    job_push_o = 1'b0;
    if (accept_i) begin
      unique case (item_i.cmd)
        CMD_RESTART: cur_d = (seed_i == '0) ? DefaultSeed : seed_i;
        CMD_DRAW: begin
          cur_d      = {1'b0, nxt};
          job_push_o = 1'b1;
        end
        default: cur_d = cur_q;
      endcase
    end
    job_o.raw  = nxt;
    job_o.low  = item_i.range_low;
    job_o.span = item_i.range_high - item_i.range_low + 32'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= DefaultSeed;
    end else begin
      cur_q <= cur_d;
    end
  end

endmodule

### sv/lrg_fifo.sv
// Two-entry queue of draws between the front end and the back end.
// Depends on lrg_pkg.
module lrg_fifo import lrg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

### sv/lrg_back.sv
// Back end: reduces the raw value by the span one bit per cycle, adds
// the lower bound and holds the result in the output register.
// Depends on lrg_pkg.
module lrg_back import lrg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_empty_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t item_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_e;

  state_e      state_q, state_d;
  logic [30:0] raw_q, raw_d;
  logic [31:0] low_q, low_d;
  logic [31:0] span_q, span_d;
  logic [31:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        vld_q, vld_d;
  out_item_t   out_q, out_d;
  logic [4:0]  bit_idx;
  logic [32:0] shifted;
  logic        out_free;

  assign empty_o  = !vld_q;
  assign item_o   = out_q;
  assign out_free = !vld_q || pop_i;
  assign bit_idx  = cnt_q - 5'd1;
  assign shifted  = {rem_q, raw_q[bit_idx]};

  always_comb begin
    state_d   = state_q;
    raw_d     = raw_q;
    low_d     = low_q;
    span_d    = span_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    vld_d     = vld_q && !pop_i;
    out_d     = out_q;
    job_pop_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          raw_d     = job_i.raw;
          low_d     = job_i.low;
          span_d    = job_i.span;
          state_d   = S_DIV;
          // Skip the loop when the span is full or exceeds the value.
          if (job_i.span == '0 || job_i.span > {1'b0, job_i.raw}) begin
            rem_d = {1'b0, job_i.raw};
            cnt_d = 5'd0;
          end else begin
            rem_d = '0;
            cnt_d = 5'd31;
          end
        end
      end
      S_DIV: begin
        if (cnt_q != 5'd0) begin
          if (shifted >= {1'b0, span_q}) begin
            rem_d = 32'(shifted - {1'b0, span_q});
          end else begin
            rem_d = shifted[31:0];
          end
          cnt_d = cnt_q - 5'd1;
        end else if (out_free) begin
          out_d.raw_value    = raw_q;
          out_d.ranged_value = low_q + rem_q;
          vld_d              = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    raw_q  <= raw_d;
    low_q  <= low_d;
    span_q <= span_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
    end
  end

endmodule

### sv/lehmer_random_generator.sv
// Lehmer generator, multiplier 48271 modulo 2^31-1, with ranged output.
// Front end steps the state on each accepted request; the back end reduces
// by the span one quotient bit per cycle and pops the next draw only once
// the last result is in the output register. Restarts give no result.
// Async active-low reset: seed and state 0x075bd924, queues empty.
module lehmer_random_generator import lrg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] seed_q;
  logic        accept;
  logic        job_push, job_pop, job_full, job_empty;
  job_t        job_in, job_out;
  reg_idx_e    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign prdata  = (reg_idx == REG_SEED) ? seed_q : '0;
  assign full    = job_full;
  assign accept  = push && !job_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= DefaultSeed;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_SEED) begin
      seed_q <= pwdata;
    end
  end

  lrg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .seed_i     (seed_q),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  lrg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  lrg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .item_o      (out_item_o)
  );

endmodule
